### design/kmfn_pkg.sv
// package for the keyframe morph face normal block: widths, word types, datapath ops
`timescale 1ns / 1ps
package kmfn_pkg;
  localparam int CB  = 24;
  localparam int BF  = 16;
  localparam int BFW = BF + 1;
  localparam int NF  = 14;
  localparam int NW  = NF + 2;
  localparam int DW  = CB + 1;
  localparam int CW  = 2 * CB + 3;
  localparam int MW  = 2 * CB + 2;
  localparam int MB  = 31;
  localparam int SW  = 64;
  localparam int RW  = 32;
  localparam int QW  = NF + 1;

  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_BLEND = 4'd2;
  localparam logic [3:0] OP_HOLD  = 4'd3;
  localparam logic [3:0] OP_DIFF  = 4'd4;
  localparam logic [3:0] OP_MUL   = 4'd5;
  localparam logic [3:0] OP_ABS   = 4'd6;
  localparam logic [3:0] OP_NORM  = 4'd7;
  localparam logic [3:0] OP_SQ    = 4'd8;
  localparam logic [3:0] OP_SINIT = 4'd9;
  localparam logic [3:0] OP_SQRT  = 4'd10;
  localparam logic [3:0] OP_DINIT = 4'd11;
  localparam logic [3:0] OP_DIV   = 4'd12;
  localparam logic [3:0] OP_DEND  = 4'd13;
  localparam logic [3:0] OP_OUT   = 4'd14;

  typedef struct packed {
    logic signed [CB-1:0] cur_x;
    logic signed [CB-1:0] cur_y;
    logic signed [CB-1:0] cur_z;
    logic signed [CB-1:0] nxt_x;
    logic signed [CB-1:0] nxt_y;
    logic signed [CB-1:0] nxt_z;
  } in_word_t;

  typedef struct packed {
    logic signed [CB-1:0] out_x;
    logic signed [CB-1:0] out_y;
    logic signed [CB-1:0] out_z;
    logic signed [NW-1:0] norm_x;
    logic signed [NW-1:0] norm_y;
    logic signed [NW-1:0] norm_z;
    logic                 triangle_done;
    logic                 degenerate;
  } out_word_t;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] sel;
    logic       tri_done;
  } cmd_t;

  typedef struct packed {
    logic nrm_hi;
    logic nrm_lo;
    logic zero;
    logic out_free;
  } stat_t;
endpackage

### design/kmfn_ctrl.sv
// controller state machine sequencing blend, cross product, sqrt and divides
`timescale 1ns / 1ps
module kmfn_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  kmfn_pkg::stat_t stat,
  output kmfn_pkg::cmd_t  cmd
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BLEND = 4'd1;
  localparam logic [3:0] S_ROUTE = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_ABS   = 4'd4;
  localparam logic [3:0] S_NORM  = 4'd5;
  localparam logic [3:0] S_SQ    = 4'd6;
  localparam logic [3:0] S_SINIT = 4'd7;
  localparam logic [3:0] S_SQRT  = 4'd8;
  localparam logic [3:0] S_DINIT = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_DEND  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [1:0] corner_r, corner_nxt;
  logic       tri_r, tri_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    corner_nxt = corner_r;
    tri_nxt    = tri_r;
    cmd.op       = kmfn_pkg::OP_NONE;
    cmd.sel      = idx_r;
    cmd.tri_done = tri_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = kmfn_pkg::OP_LOAD;
          idx_nxt   = 3'd0;
          state_nxt = S_BLEND;
        end
      end
      S_BLEND: begin
        cmd.op = kmfn_pkg::OP_BLEND;
        if (idx_r == 3'd2) begin
          state_nxt = S_ROUTE;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      S_ROUTE: begin
        cmd.sel = {1'b0, corner_r};
        idx_nxt = 3'd0;
        if (corner_r != 2'd2) begin
          cmd.op     = kmfn_pkg::OP_HOLD;
          corner_nxt = corner_r + 2'd1;
          tri_nxt    = 1'b0;
          state_nxt  = S_OUT;
        end else begin
          cmd.op     = kmfn_pkg::OP_DIFF;
          corner_nxt = 2'd0;
          tri_nxt    = 1'b1;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op = kmfn_pkg::OP_MUL;
        if (idx_r == 3'd5) begin
          state_nxt = S_ABS;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      S_ABS: begin
        cmd.op    = kmfn_pkg::OP_ABS;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        idx_nxt = 3'd0;
        if (stat.zero) begin
          state_nxt = S_OUT;
        end else if (stat.nrm_hi || stat.nrm_lo) begin
          cmd.op = kmfn_pkg::OP_NORM;
        end else begin
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op = kmfn_pkg::OP_SQ;
        if (idx_r == 3'd2) begin
          state_nxt = S_SINIT;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      S_SINIT: begin
        cmd.op    = kmfn_pkg::OP_SINIT;
        cnt_nxt   = 5'd0;
        idx_nxt   = 3'd0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = kmfn_pkg::OP_SQRT;
        if (cnt_r == 5'(kmfn_pkg::RW - 1)) begin
          state_nxt = S_DINIT;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_DINIT: begin
        cmd.op    = kmfn_pkg::OP_DINIT;
        cnt_nxt   = 5'd0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = kmfn_pkg::OP_DIV;
        if (cnt_r == 5'(kmfn_pkg::NF)) begin
          state_nxt = S_DEND;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_DEND: begin
        cmd.op = kmfn_pkg::OP_DEND;
        if (idx_r == 3'd2) begin
          state_nxt = S_OUT;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = S_DINIT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op    = kmfn_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= 3'd0;
      cnt_r    <= 5'd0;
      corner_r <= 2'd0;
      tri_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      cnt_r    <= cnt_nxt;
      corner_r <= corner_nxt;
      tri_r    <= tri_nxt;
    end
  end
endmodule

### design/kmfn_dp.sv
// datapath: blend multiplier, held corners, cross product, normalize, sqrt and divider
`timescale 1ns / 1ps
module kmfn_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  kmfn_pkg::in_word_t             in_word,
  input  logic                           cfg_we,
  input  logic [kmfn_pkg::BFW-1:0]       cfg_wdata,
  output logic                           out_valid,
  input  logic                           out_stall,
  output kmfn_pkg::out_word_t            out_word,
  input  kmfn_pkg::cmd_t                 cmd,
  output kmfn_pkg::stat_t                stat
);
  localparam int CB = kmfn_pkg::CB;
  localparam int DW = kmfn_pkg::DW;
  localparam int CW = kmfn_pkg::CW;
  localparam int MW = kmfn_pkg::MW;
  localparam int MB = kmfn_pkg::MB;
  localparam int SW = kmfn_pkg::SW;
  localparam int RW = kmfn_pkg::RW;
  localparam int QW = kmfn_pkg::QW;
  localparam int NW = kmfn_pkg::NW;
  localparam int BFW = kmfn_pkg::BFW;

  logic [BFW-1:0]       bf_r;
  kmfn_pkg::in_word_t   in_r;
  logic signed [CB-1:0] v_r [3];
  logic signed [CB-1:0] hold_r [6];
  logic signed [DW-1:0] a_r [3];
  logic signed [DW-1:0] b_r [3];
  logic signed [CW-1:0] cross_r [3];
  logic [MW-1:0]        mag_r [3];
  logic                 neg_r [3];
  logic [SW-1:0]        sum_r;
  logic [SW-1:0]        x_r;
  logic [RW+1:0]        srem_r;
  logic [RW-1:0]        root_r;
  logic [RW+1:0]        drem_r;
  logic [QW-1:0]        q_r;
  logic signed [NW-1:0] nrm_r [3];
  logic                 degen_r;
  logic                 ovalid_r;
  kmfn_pkg::out_word_t  out_r;

  logic [BFW-1:0]         f_sat;
  logic signed [CB-1:0]   bc, bn;
  logic signed [DW-1:0]   bdiff;
  logic signed [DW+BFW:0] bprod;
  logic signed [DW+BFW:0] bsh;
  logic signed [DW-1:0]   mop1, mop2;
  logic signed [2*DW-1:0] mprod;
  logic [1:0]             mt;
  logic [MW-1:0]          orv;
  logic [2*MB-1:0]        sq;
  logic [RW+1:0]          srem_t, strial, dsub;
  logic                   sge, dge;
  logic signed [NW-1:0]   qe;
  logic [1:0]             s2;

  assign f_sat = bf_r[BFW-1] ? {1'b1, {(BFW-1){1'b0}}} : bf_r;
  assign s2    = cmd.sel[1:0];

  always_comb begin
    case (s2)
      2'd0: begin bc = in_r.cur_x; bn = in_r.nxt_x; end
      2'd1: begin bc = in_r.cur_y; bn = in_r.nxt_y; end
      default: begin bc = in_r.cur_z; bn = in_r.nxt_z; end
    endcase
    bdiff = {bn[CB-1], bn} - {bc[CB-1], bc};
    bprod = bdiff * $signed({1'b0, f_sat});
    bsh   = bprod >>> kmfn_pkg::BF;
  end

  always_comb begin
    case (cmd.sel)
      3'd0: begin mop1 = a_r[1]; mop2 = b_r[2]; mt = 2'd0; end
      3'd1: begin mop1 = b_r[1]; mop2 = a_r[2]; mt = 2'd0; end
      3'd2: begin mop1 = b_r[0]; mop2 = a_r[2]; mt = 2'd1; end
      3'd3: begin mop1 = a_r[0]; mop2 = b_r[2]; mt = 2'd1; end
      3'd4: begin mop1 = a_r[0]; mop2 = b_r[1]; mt = 2'd2; end
      default: begin mop1 = b_r[0]; mop2 = a_r[1]; mt = 2'd2; end
    endcase
    mprod = mop1 * mop2;
  end

  assign orv    = mag_r[0] | mag_r[1] | mag_r[2];
  assign sq     = mag_r[s2][MB-1:0] * mag_r[s2][MB-1:0];
  assign srem_t = {srem_r[RW-1:0], x_r[SW-1:SW-2]};
  assign strial = {root_r, 2'b01};
  assign sge    = (srem_t >= strial);
  assign dge    = (drem_r >= {2'b00, root_r});
  assign dsub   = dge ? (drem_r - {2'b00, root_r}) : drem_r;
  assign qe     = $signed({{(NW-QW){1'b0}}, q_r});

  assign stat.nrm_hi   = |orv[MW-1:MB];
  assign stat.nrm_lo   = !(|orv[MW-1:MB]) && !orv[MB-1];
  assign stat.zero     = (orv == '0);
  assign stat.out_free = !ovalid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bf_r <= '0;
    end else if (cfg_we) begin
      bf_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.op == kmfn_pkg::OP_OUT) begin
      ovalid_r <= 1'b1;
    end else if (!out_stall) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      kmfn_pkg::OP_LOAD: begin
        in_r <= in_word;
      end
      kmfn_pkg::OP_BLEND: begin
        v_r[s2] <= bc + bsh[CB-1:0];
      end
      kmfn_pkg::OP_HOLD: begin
        for (int i = 0; i < 3; i++) begin
          hold_r[3*s2 + i] <= v_r[i];
        end
      end
      kmfn_pkg::OP_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          a_r[i] <= {hold_r[i][CB-1], hold_r[i]} - {hold_r[3+i][CB-1], hold_r[3+i]};
          b_r[i] <= {hold_r[i][CB-1], hold_r[i]} - {v_r[i][CB-1], v_r[i]};
        end
      end
      kmfn_pkg::OP_MUL: begin
        if (!cmd.sel[0]) begin
          cross_r[mt] <= {mprod[2*DW-1], mprod};
        end else begin
          cross_r[mt] <= cross_r[mt] - {mprod[2*DW-1], mprod};
        end
      end
      kmfn_pkg::OP_ABS: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= cross_r[i][CW-1];
          mag_r[i] <= cross_r[i][CW-1] ? MW'(-cross_r[i]) : MW'(cross_r[i]);
          nrm_r[i] <= '0;
        end
        degen_r <= (cross_r[0] == '0) && (cross_r[1] == '0) && (cross_r[2] == '0);
      end
      kmfn_pkg::OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (stat.nrm_hi) begin
            mag_r[i] <= mag_r[i] >> 1;
          end else begin
            mag_r[i] <= mag_r[i] << 1;
          end
        end
      end
      kmfn_pkg::OP_SQ: begin
        sum_r <= ((s2 == 2'd0) ? '0 : sum_r) + SW'(sq);
      end
      kmfn_pkg::OP_SINIT: begin
        x_r    <= sum_r;
        srem_r <= '0;
        root_r <= '0;
      end
      kmfn_pkg::OP_SQRT: begin
        srem_r <= sge ? (srem_t - strial) : srem_t;
        root_r <= {root_r[RW-2:0], sge};
        x_r    <= x_r << 2;
      end
      kmfn_pkg::OP_DINIT: begin
        drem_r <= (RW+2)'(mag_r[s2][MB-1:0]);
        q_r    <= '0;
      end
      kmfn_pkg::OP_DIV: begin
        drem_r <= {dsub[RW:0], 1'b0};
        q_r    <= {q_r[QW-2:0], dge};
      end
      kmfn_pkg::OP_DEND: begin
        nrm_r[s2] <= neg_r[s2] ? -qe : qe;
      end
      kmfn_pkg::OP_OUT: begin
        out_r.out_x         <= v_r[0];
        out_r.out_y         <= v_r[1];
        out_r.out_z         <= v_r[2];
        out_r.norm_x        <= cmd.tri_done ? nrm_r[0] : '0;
        out_r.norm_y        <= cmd.tri_done ? nrm_r[1] : '0;
        out_r.norm_z        <= cmd.tri_done ? nrm_r[2] : '0;
        out_r.triangle_done <= cmd.tri_done;
        out_r.degenerate    <= cmd.tri_done && degen_r;
      end
      default: begin
      end
    endcase
  end

  assign out_valid = ovalid_r;
  assign out_word  = out_r;
endmodule

### design/keyframe_morph_face_normal.sv
// top level: keyframe vertex blend with face normal on every third vertex
// first two corners of a triangle: the blended vertex is held and output with a zero normal
// third corner: up to 30 one-bit normalize shifts, the 32-step square root and three divides
// on one shared divider, all skipped when the normal is zero (flagged degenerate)
// one word in flight at a time; a stalled result holds the controller before it returns to idle
// reset (rst_n low, synchronous) clears the blend factor, the corner count and the handshakes
`timescale 1ns / 1ps
module keyframe_morph_face_normal (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  kmfn_pkg::in_word_t         in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output kmfn_pkg::out_word_t        out_word,
  input  logic                       cfg_we,
  input  logic [kmfn_pkg::BFW-1:0]   cfg_wdata
);
  kmfn_pkg::cmd_t  cmd;
  kmfn_pkg::stat_t stat;

  kmfn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  kmfn_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cmd       (cmd),
    .stat      (stat)
  );
endmodule

### tb/tb_keyframe_morph_face_normal.sv
// testbench for keyframe_morph_face_normal: random vertex stream, blend and face normal check
`timescale 1ns / 1ps
module tb_keyframe_morph_face_normal;
  localparam int BFW = kmfn_pkg::BFW;
  localparam int CB  = kmfn_pkg::CB;
  localparam int BF  = kmfn_pkg::BF;
  localparam int MB  = kmfn_pkg::MB;
  localparam int NF  = kmfn_pkg::NF;
  localparam int NW  = kmfn_pkg::NW;

  localparam logic [BFW-1:0] FACTOR_ONE = 17'd65536;
  localparam int             CFG_BLEND  = 0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  kmfn_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  kmfn_pkg::out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [BFW-1:0] cfg_wdata = '0;

  kmfn_pkg::in_word_t  vertex_queue[$];
  kmfn_pkg::out_word_t blended_queue[$];
  logic [BFW-1:0] blend_reg;
  int corners_held;
  logic signed [CB-1:0] corner_store[6];
  int errors = 0;
  int cycle_no = 0;
  int words_in = 0;
  int triangles_seen = 0;
  int degen_seen = 0;

  keyframe_morph_face_normal dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic kmfn_pkg::out_word_t blend_and_normal(kmfn_pkg::in_word_t w);
    kmfn_pkg::out_word_t o;
    longint f, cc, nn, vv;
    longint v[3];
    longint a[3], b[3], c[3];
    longint unsigned mag[3], m[3], sum, len, q;
    logic neg[3];
    int lb, l, i;
    logic [3*CB-1:0] cur, nxt;
    o = '0;
    f = (blend_reg > FACTOR_ONE) ? longint'(FACTOR_ONE) : longint'(blend_reg);
    cur = {w.cur_x, w.cur_y, w.cur_z};
    nxt = {w.nxt_x, w.nxt_y, w.nxt_z};
    for (i = 0; i < 3; i++) begin
      cc = longint'($signed(cur[(2-i)*CB +: CB]));
      nn = longint'($signed(nxt[(2-i)*CB +: CB]));
      vv = cc + ((f * (nn - cc)) >>> BF);
      v[i] = longint'($signed(vv[CB-1:0]));
    end
    o.out_x = v[0][CB-1:0];
    o.out_y = v[1][CB-1:0];
    o.out_z = v[2][CB-1:0];
    if (corners_held < 2) begin
      for (i = 0; i < 3; i++) corner_store[corners_held*3 + i] = v[i][CB-1:0];
      corners_held++;
      return o;
    end
    corners_held = 0;
    for (i = 0; i < 3; i++) begin
      a[i] = longint'(corner_store[i]) - longint'(corner_store[3+i]);
      b[i] = longint'(corner_store[i]) - v[i];
    end
    c[0] = a[1] * b[2] - b[1] * a[2];
    c[1] = b[0] * a[2] - a[0] * b[2];
    c[2] = a[0] * b[1] - b[0] * a[1];
    lb = 0;
    for (i = 0; i < 3; i++) begin
      neg[i] = c[i] < 0;
      mag[i] = neg[i] ? longint'(-c[i]) : c[i];
      l = 0;
      while ((mag[i] >> l) != 0) l++;
      if (l > lb) lb = l;
    end
    o.triangle_done = 1'b1;
    if (lb == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    sum = 0;
    for (i = 0; i < 3; i++) begin
      m[i] = (lb > MB) ? (mag[i] >> (lb - MB)) : (mag[i] << (MB - lb));
      m[i] = m[i] & 64'h7fff_ffff;
      sum += m[i] * m[i];
    end
    len = root_floor(sum);
    for (i = 0; i < 3; i++) begin
      q = (m[i] << NF) / len;
      if (neg[i]) q = -q;
      case (i)
        0: o.norm_x = q[NW-1:0];
        1: o.norm_y = q[NW-1:0];
        default: o.norm_z = q[NW-1:0];
      endcase
    end
    return o;
  endfunction

  function automatic logic want_idle();
    if (cycle_no > 20000 && cycle_no < 32000) return 1'b0;
    return $urandom_range(0, 99) < 17;
  endfunction

  // driver
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        blended_queue.push_back(blend_and_normal(in_word));
        void'(vertex_queue.pop_front());
        words_in++;
      end
      if (!in_valid || !in_stall) begin
        if (vertex_queue.size() > 0 && !want_idle()) begin
          in_valid <= 1'b1;
          in_word <= vertex_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_stall <= rst_n ? want_idle() : 1'b0;
    if (rst_n && out_valid && !out_stall) begin
      if (blended_queue.size() == 0) begin
        $error("unexpected result word %h", out_word);
        errors++;
      end else begin
        kmfn_pkg::out_word_t e;
        e = blended_queue.pop_front();
        if (out_word.out_x !== e.out_x) begin
          $error("out_x exp %h got %h", e.out_x, out_word.out_x); errors++;
        end
        if (out_word.out_y !== e.out_y) begin
          $error("out_y exp %h got %h", e.out_y, out_word.out_y); errors++;
        end
        if (out_word.out_z !== e.out_z) begin
          $error("out_z exp %h got %h", e.out_z, out_word.out_z); errors++;
        end
        if (out_word.norm_x !== e.norm_x) begin
          $error("norm_x exp %h got %h", e.norm_x, out_word.norm_x); errors++;
        end
        if (out_word.norm_y !== e.norm_y) begin
          $error("norm_y exp %h got %h", e.norm_y, out_word.norm_y); errors++;
        end
        if (out_word.norm_z !== e.norm_z) begin
          $error("norm_z exp %h got %h", e.norm_z, out_word.norm_z); errors++;
        end
        if (out_word.triangle_done !== e.triangle_done) begin
          $error("triangle_done exp %b got %b", e.triangle_done, out_word.triangle_done);
          errors++;
        end
        if (out_word.degenerate !== e.degenerate) begin
          $error("degenerate exp %b got %b", e.degenerate, out_word.degenerate); errors++;
        end
        if (e.triangle_done) triangles_seen++;
        if (e.degenerate) degen_seen++;
      end
    end
  end

  function automatic logic signed [CB-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return CB'($urandom);
      1: return CB'($urandom_range(0, 4000)) - CB'(2000);
      2: return {1'b1, {(CB-1){1'b0}}};
      3: return {1'b0, {(CB-1){1'b1}}};
      default: return CB'($urandom_range(0, 200000)) - CB'(100000);
    endcase
  endfunction

  task automatic add_vertex(input logic signed [CB-1:0] cx, cy, cz, nx, ny, nz);
    kmfn_pkg::in_word_t w;
    w = '{cur_x: cx, cur_y: cy, cur_z: cz, nxt_x: nx, nxt_y: ny, nxt_z: nz};
    vertex_queue.push_back(w);
  endtask

  task automatic add_random_vertex();
    add_vertex(rand_coord(), rand_coord(), rand_coord(),
               rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic drain_and_set(input logic [BFW-1:0] factor);
    while (vertex_queue.size() > 0 || blended_queue.size() > 0 || in_valid)
      @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= factor;
    blend_reg = factor;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic signed [CB-1:0] lo, hi;
    int k, n;
    logic [BFW-1:0] factors[6];
    lo = {1'b1, {(CB-1){1'b0}}};
    hi = {1'b0, {(CB-1){1'b1}}};
    blend_reg = '0;
    corners_held = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // factor zero from reset: extremes, degenerate and collinear triangles
    add_vertex(lo, hi, lo, hi, lo, hi);
    add_vertex(hi, lo, hi, lo, hi, lo);
    add_vertex(lo, lo, hi, hi, hi, lo);
    add_vertex(5, 5, 5, 0, 0, 0);
    add_vertex(5, 5, 5, 0, 0, 0);
    add_vertex(5, 5, 5, 0, 0, 0);
    add_vertex(0, 0, 0, 0, 0, 0);
    add_vertex(100, 200, 300, 0, 0, 0);
    add_vertex(200, 400, 600, 0, 0, 0);
    add_vertex(0, 0, 0, 1, 1, 1);
    add_vertex(1, 0, 0, 1, 1, 1);
    drain_and_set(FACTOR_ONE);
    // mid triangle factor change: one more vertex completes the group
    add_vertex(0, 0, 0, 0, 1, 0);
    add_vertex(lo, lo, lo, hi, hi, hi);
    add_vertex(hi, hi, hi, lo, lo, lo);
    add_vertex(0, 0, 0, hi, lo, 7);
    drain_and_set({BFW{1'b1}});
    add_vertex(lo, 0, hi, hi, 0, lo);
    add_vertex(3, -7, 11, 2000, -3000, 4000);
    drain_and_set(17'd32768);
    for (k = 0; k < 3; k++) add_random_vertex();
    factors = '{17'd0, FACTOR_ONE, 17'd1, 17'd65535, 17'd100000, 17'd0};
    for (n = 0; n < 6; n++) begin
      factors[5] = BFW'($urandom_range(0, 65536));
      drain_and_set(factors[n]);
      for (k = 0; k < 250 + n; k++) add_random_vertex();
    end
    while (vertex_queue.size() > 0 || blended_queue.size() > 0 || in_valid)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (blended_queue.size() != 0) begin
      $error("%0d expected results never arrived", blended_queue.size());
      errors++;
    end
    $display("sent %0d vertices over several blend factors incl. zero, one and above one",
             words_in);
    $display("checked %0d triangles, %0d of them degenerate", triangles_seen, degen_seen);
    if (errors == 0) begin
      $display("[keyframe_morph_face_normal] OK");
    end else begin
      $display("[keyframe_morph_face_normal] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[keyframe_morph_face_normal] ERROR");
    $finish;
  end
endmodule
